// File: hw/rtl/u8u16_pkg.sv
// u8u16_pkg: shared types, constants and byte helpers of the utf-8 to utf-16 transcoder
// used by u8u16_decode and utf8_to_utf16_transcoder; depends on nothing
`default_nettype none

package u8u16_pkg;

    // stream widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned MAX_RES = 3;

    // unit given for a bad or cut-short lead byte
    localparam logic [UNIT_W-1:0] BAD_UNIT = 16'h0023;

    // code point limits and surrogate bases
    localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h010000;
    localparam logic [CP_W-1:0]   CP_LIMIT     = 21'h110000;
    localparam logic [UNIT_W-1:0] SURR_HIGH    = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_LOW     = 16'hDC00;

    // one result item
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              no_unit;
        logic              end_of_string;
    } result_t;

    // partial sequence held between bytes
    typedef struct packed {
        logic [2:0][BYTE_W-1:0] bytes;
        logic [1:0]             count;
        logic [2:0]             exp_len;
    } pend_t;

    // sequence length announced by a lead byte, 1 for ascii and bad leads
    function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        begin
            if ((b & 8'hE0) == 8'hC0)
                len = 3'd2;
            else if ((b & 8'hF0) == 8'hE0)
                len = 3'd3;
            else if ((b & 8'hF8) == 8'hF0)
                len = 3'd4;
            else
                len = 3'd1;
            return len;
        end
    endfunction

    // a byte taken alone: ascii passes, anything else is bad
    function automatic logic [UNIT_W-1:0] single_unit(input logic [BYTE_W-1:0] b);
        logic [UNIT_W-1:0] u;
        begin
            if (b[7] == 1'b0)
                u = {8'h00, b};
            else
                u = BAD_UNIT;
            return u;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/u8u16_decode.sv
// u8u16_decode: combinational decode of one byte against the held partial sequence
// gives up to three result items and the next partial sequence; depends on u8u16_pkg
`default_nettype none

module u8u16_decode (
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       last_byte,
    input  wire u8u16_pkg::pend_t           pend,
    output u8u16_pkg::result_t [2:0]        results,
    output logic [1:0]                      res_count,
    output u8u16_pkg::pend_t                pend_next
);

    logic [3:0][7:0]  buf_b;
    logic [2:0]       m;
    logic [2:0]       need;
    logic [2:0]       len0;
    logic             complete;
    logic [20:0]      cp;
    logic [20:0]      v;
    logic [2:0][15:0] units;
    logic [1:0]       n;
    logic             none;

    // assemble the sequence: held bytes then the new one
    always_comb
    begin
        buf_b = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < pend.count)
                buf_b[i] = pend.bytes[i];
        end
        buf_b[pend.count] = data_byte;
    end

    assign m        = {1'b0, pend.count} + 3'd1;
    assign need     = (pend.count == 2'd0) ? u8u16_pkg::lead_len(data_byte) : pend.exp_len;
    assign complete = (m >= need);
    assign len0     = u8u16_pkg::lead_len(buf_b[0]);

    // code point of a complete sequence
    always_comb
    begin
        if (buf_b[0][7] == 1'b0)
            cp = {13'd0, buf_b[0]};
        else if (len0 == 3'd2)
            cp = {10'd0, buf_b[0][4:0], buf_b[1][5:0]};
        else if (len0 == 3'd3)
            cp = {5'd0, buf_b[0][3:0], buf_b[1][5:0], buf_b[2][5:0]};
        else if (len0 == 3'd4)
            cp = {buf_b[0][2:0], buf_b[1][5:0], buf_b[2][5:0], buf_b[3][5:0]};
        else
            cp = {5'd0, u8u16_pkg::BAD_UNIT};
    end

    assign v = cp - u8u16_pkg::CP_SUPP_BASE;

    // units of this byte, complete sequence or cut-short replay at end of string
    always_comb
    begin
        units = '0;
        n     = 2'd0;
        none  = 1'b0;
        if (complete)
        begin
            if (cp < u8u16_pkg::CP_SUPP_BASE)
            begin
                units[0] = cp[15:0];
                n        = 2'd1;
            end
            else if (cp < u8u16_pkg::CP_LIMIT)
            begin
                units[0] = u8u16_pkg::SURR_HIGH | {6'd0, v[19:10]};
                units[1] = u8u16_pkg::SURR_LOW | {6'd0, v[9:0]};
                n        = 2'd2;
            end
        end
        else if (last_byte)
        begin
            // the held lead never fits, later bytes are retried as leads
            units[0] = u8u16_pkg::BAD_UNIT;
            n        = 2'd1;
            if (m == 3'd3 && u8u16_pkg::lead_len(buf_b[1]) == 3'd2)
            begin
                units[1] = {5'd0, buf_b[1][4:0], buf_b[2][5:0]};
                n        = 2'd2;
            end
            else if (m >= 3'd2)
            begin
                units[1] = u8u16_pkg::single_unit(buf_b[1]);
                n        = 2'd2;
                if (m == 3'd3)
                begin
                    units[2] = u8u16_pkg::single_unit(buf_b[2]);
                    n        = 2'd3;
                end
            end
        end
        // end mark with no unit
        if (last_byte && n == 2'd0)
        begin
            units[0] = '0;
            n        = 2'd1;
            none     = 1'b1;
        end
    end

    // pack results, end mark on the final one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            results[i].code_unit     = units[i];
            results[i].no_unit       = (i == 0) ? none : 1'b0;
            results[i].end_of_string = last_byte && (2'(i) == n - 2'd1);
        end
    end

    assign res_count = n;

    // next partial sequence
    always_comb
    begin
        pend_next = pend;
        if (complete || last_byte)
        begin
            pend_next = '0;
        end
        else
        begin
            pend_next.bytes[pend.count] = data_byte;
            pend_next.count             = m[1:0];
            if (pend.count == 2'd0)
                pend_next.exp_len = need;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/utf8_to_utf16_transcoder.sv
// utf8_to_utf16_transcoder: top level, partial sequence state and result buffer;
// depends on u8u16_pkg and u8u16_decode
// a byte's first result appears on m_* in the cycle after its transfer on s_*
// throughput: one byte per cycle; a byte giving k results holds s_tready low until
//   only its last result remains and m_tready is high (result buffer drain), bytes giving no result never stall
// reset (rst_n low, asynchronous): partial sequence and result buffer cleared
`default_nettype none

module utf8_to_utf16_transcoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] code_unit
    output logic             m_tuser,   // [0] no_unit
    output logic             m_tlast    // end_of_string
);

    u8u16_pkg::pend_t          pend_reg;
    u8u16_pkg::pend_t          pend_next;
    u8u16_pkg::result_t [2:0]  dec_res;
    logic [1:0]                dec_cnt;
    u8u16_pkg::result_t [2:0]  res_reg;
    u8u16_pkg::result_t [2:0]  res_next;
    logic [1:0]                cnt_reg;
    logic [1:0]                cnt_next;
    logic                      accept;
    logic                      pop;

    // byte decode
    u8u16_decode u_decode (
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .pend      (pend_reg),
        .results   (dec_res),
        .res_count (dec_cnt),
        .pend_next (pend_next)
    );

    // handshakes: take a byte once the buffer is empty or its last entry leaves
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign accept   = s_tvalid && s_tready;

    // result buffer: load on transfer in, shift down on transfer out
    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            res_next = dec_res;
            cnt_next = dec_cnt;
        end
        else if (pop)
        begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            pend_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
                pend_reg <= pend_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_tdata = res_reg[0].code_unit;
    assign m_tuser = res_reg[0].no_unit;
    assign m_tlast = res_reg[0].end_of_string;

    // end-only result is always the final and only one
    a_no_unit_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && cnt_reg == 2'd1))
        else $error("no-unit result not alone or not marked last");

    // last byte leaves no partial sequence
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (pend_reg.count == 2'd0 && pend_reg.exp_len == 3'd0))
        else $error("partial sequence kept after last byte");

    // held bytes stay below the announced length
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg.count != 2'd0) |->
            (pend_reg.exp_len >= 3'd2 && {1'b0, pend_reg.count} < pend_reg.exp_len))
        else $error("partial sequence length out of range");

    // draining without a new byte drops exactly one entry
    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !accept) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("result buffer count slip");

    // a new byte only arrives when the buffer empties that cycle
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (cnt_reg == 2'd0 || pop))
        else $error("byte taken over pending results");

endmodule

`default_nettype wire

// File: verif/utf8_to_utf16_checker.sv
// utf8_to_utf16_checker: watches both stream channels of the transcoder, predicts the
// utf-16 units of every accepted byte and compares them with the units that come out
// depends on u8u16_pkg for the result type and the code point constants
`timescale 1ns / 100ps

module utf8_to_utf16_checker
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    input  wire logic        s_tlast,    // last_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,    // [15:0] code_unit
    input  wire logic        m_tuser,    // [0] no_unit
    input  wire logic        m_tlast,    // end_of_string
    output int               error_count,
    output int               units_pending,
    output int               units_checked
);

    // units still owed by the block, oldest first
    result_t units_due[$];

    // partial sequence mirrored from the byte stream
    logic [2:0][7:0] held_bytes;
    int unsigned     held_count;
    int unsigned     announced_len;

    int mismatch_count;
    int checked_count;

    // sequence length a lead byte asks for, bad leads count as one byte
    function automatic int unsigned lead_span(input logic [7:0] lead);
        if (lead[7:5] == 3'b110)
            return 2;
        else if (lead[7:4] == 4'b1110)
            return 3;
        else if (lead[7:3] == 5'b11110)
            return 4;
        return 1;
    endfunction

    // decode one sequence starting at byte 'at' using at most 'avail' bytes
    function automatic logic [20:0] decode_cp(input logic [3:0][7:0] seq,
                                              input int unsigned at,
                                              input int unsigned avail,
                                              output int unsigned used);
        logic [3:0][7:0] s;
        logic [20:0]     cp;
        s    = seq >> (8 * at);
        used = 1;
        cp   = {5'd0, BAD_UNIT};
        if (avail == 0)
            cp = {5'd0, BAD_UNIT};
        else if (s[0][7] == 1'b0)
            cp = {13'd0, s[0]};
        else if (s[0][7:5] == 3'b110 && avail > 1)
        begin
            used = 2;
            cp   = {10'd0, s[0][4:0], s[1][5:0]};
        end
        else if (s[0][7:4] == 4'b1110 && avail > 2)
        begin
            used = 3;
            cp   = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
        end
        else if (s[0][7:3] == 5'b11110 && avail > 3)
        begin
            used = 4;
            cp   = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        end
        return cp;
    endfunction

    task automatic queue_unit(input logic [15:0] unit);
        result_t r;
        r.code_unit     = unit;
        r.no_unit       = 1'b0;
        r.end_of_string = 1'b0;
        units_due.push_back(r);
    endtask

    // bmp code points give one unit, supplementary ones a surrogate pair, the rest nothing
    task automatic queue_code_point(input logic [20:0] cp);
        logic [20:0] offset;
        offset = cp - CP_SUPP_BASE;
        if (cp < CP_SUPP_BASE)
            queue_unit(cp[15:0]);
        else if (cp < CP_LIMIT)
        begin
            queue_unit(SURR_HIGH + {6'd0, offset[19:10]});
            queue_unit(SURR_LOW + {6'd0, offset[9:0]});
        end
    endtask

    task automatic forget_sequence();
        held_bytes    = '0;
        held_count    = 0;
        announced_len = 0;
    endtask

    // expected units of one accepted byte
    task automatic predict_byte(input logic [7:0] data_byte, input logic last_byte);
        logic [3:0][7:0] seq;
        logic [20:0]     cp;
        int unsigned     idx;
        int unsigned     total;
        int unsigned     need;
        int unsigned     pos;
        int unsigned     used;
        int unsigned     queued_before;
        result_t         tail;
        seq = '0;
        for (idx = 0; idx < held_count; idx++)
            seq[idx] = held_bytes[idx];
        seq[held_count] = data_byte;
        total = held_count + 1;
        need  = (total == 1) ? lead_span(data_byte) : announced_len;
        queued_before = units_due.size();

        if (total >= need)
        begin
            cp = decode_cp(seq, 0, total, used);
            queue_code_point(cp);
            forget_sequence();
        end
        else if (last_byte)
        begin
            // sequence cut short by the end of string: rescan byte by byte
            pos = 0;
            while (pos < total)
            begin
                cp = decode_cp(seq, pos, total - pos, used);
                queue_code_point(cp);
                pos = pos + used;
            end
            forget_sequence();
        end
        else
        begin
            for (idx = 0; idx < total; idx++)
                held_bytes[idx] = seq[idx];
            held_count = total;
            if (total == 1)
                announced_len = need;
        end

        // end of string always gets a marked unit, a bare marker if nothing came
        if (last_byte)
        begin
            if (units_due.size() == queued_before)
            begin
                tail.code_unit     = '0;
                tail.no_unit       = 1'b1;
                tail.end_of_string = 1'b0;
                units_due.push_back(tail);
            end
            tail = units_due.pop_back();
            tail.end_of_string = 1'b1;
            units_due.push_back(tail);
        end
    endtask

    // compare one output transfer against the oldest expected unit
    task automatic check_result();
        result_t due;
        if (units_due.size() == 0)
        begin
            $error("unexpected result: code_unit 0x%04h no_unit %0d end_of_string %0d",
                   m_tdata, m_tuser, m_tlast);
            mismatch_count++;
        end
        else
        begin
            due = units_due.pop_front();
            if (m_tdata !== due.code_unit)
            begin
                $error("code_unit: expected 0x%04h, actual 0x%04h", due.code_unit, m_tdata);
                mismatch_count++;
            end
            if (m_tuser !== due.no_unit)
            begin
                $error("no_unit: expected %0d, actual %0d", due.no_unit, m_tuser);
                mismatch_count++;
            end
            if (m_tlast !== due.end_of_string)
            begin
                $error("end_of_string: expected %0d, actual %0d", due.end_of_string, m_tlast);
                mismatch_count++;
            end
            checked_count++;
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forget_sequence();
            units_due.delete();
            mismatch_count = 0;
            checked_count  = 0;
            error_count   <= 0;
            units_pending <= 0;
            units_checked <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            error_count   <= mismatch_count;
            units_pending <= units_due.size();
            units_checked <= checked_count;
        end
    end

endmodule

// File: verif/tb_utf8_to_utf16_transcoder.sv
// tb_utf8_to_utf16_transcoder: drives utf-8 strings into the transcoder with bursty
// input and a stalling sink, and gives the verdict from utf8_to_utf16_checker
// depends on utf8_to_utf16_transcoder and utf8_to_utf16_checker
`timescale 1ns / 100ps

module tb_utf8_to_utf16_transcoder;

    localparam int RANDOM_BYTES = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int SINK_PHASE   = 150;

    // sink stall patterns
    localparam int SINK_OPEN    = 0;
    localparam int SINK_RANDOM  = 1;
    localparam int SINK_PULSED  = 2;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tlast;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;    // [15:0] code_unit
    logic        m_tuser;    // [0] no_unit
    logic        m_tlast;    // end_of_string

    int error_count;
    int units_pending;
    int units_checked;

    int          burst_left;
    int          bytes_sent;
    int          strings_sent;
    int          sink_cycle = 0;
    logic [7:0]  text_bytes[$];

    utf8_to_utf16_transcoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_to_utf16_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .units_pending (units_pending),
        .units_checked (units_checked)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sink stalls: open, random, then a fixed pulse train, in turn
    always @(posedge clk)
    begin
        sink_cycle = sink_cycle + 1;
        case ((sink_cycle / SINK_PHASE) % 3)
            SINK_OPEN:   m_tready <= 1'b1;
            SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
            default:     m_tready <= ((sink_cycle % 7) < 3);
        endcase
    end

    // one byte transfer, with a random gap whenever a burst runs out
    task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tlast  <= last_byte;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
        if (last_byte)
            strings_sent++;
    endtask

    // continuation byte, now and then a random one since these go unchecked
    function automatic logic [7:0] follow_byte(input logic [5:0] bits);
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return {2'b10, bits};
    endfunction

    // append one character to the string: mostly well formed, some noise and cut sequences
    task automatic append_char();
        int unsigned     kind;
        int unsigned     len;
        int unsigned     keep;
        int unsigned     idx;
        logic [20:0]     cp;
        logic [3:0][7:0] enc;
        kind = $urandom_range(0, 19);
        enc  = '0;
        if (kind < 6)
        begin
            len = 1;
            cp  = 21'($urandom_range(0, 8'h7F));
        end
        else if (kind < 10)
        begin
            len = 2;
            cp  = 21'($urandom_range(0, 11'h7FF));
        end
        else if (kind < 14)
        begin
            len = 3;
            cp  = 21'($urandom_range(0, 16'hFFFF));
        end
        else if (kind < 16)
        begin
            len = 4;
            cp  = 21'($urandom_range(21'h010000, 21'h10FFFF));
        end
        else if (kind == 16)
        begin
            // beyond the unicode range, gives no unit
            len = 4;
            cp  = 21'($urandom_range(21'h110000, 21'h1FFFFF));
        end
        else
        begin
            len = $urandom_range(2, 4);
            cp  = 21'($urandom_range(0, 21'h1FFFFF));
        end

        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = follow_byte(cp[5:0]);
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = follow_byte(cp[11:6]);
                enc[2] = follow_byte(cp[5:0]);
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = follow_byte(cp[17:12]);
                enc[2] = follow_byte(cp[11:6]);
                enc[3] = follow_byte(cp[5:0]);
            end
        endcase

        if (kind == 17)
            text_bytes.push_back(8'($urandom_range(0, 255)));
        else
        begin
            // broken sequence: drop its tail
            keep = (kind >= 18) ? $urandom_range(1, len - 1) : len;
            for (idx = 0; idx < keep; idx++)
                text_bytes.push_back(enc[idx]);
        end
    endtask

    // stimulus
    initial
    begin
        int directed_bytes;
        int n_chars;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        burst_left   = 0;
        bytes_sent   = 0;
        strings_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ascii extremes and bad leads
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // two, three and four byte forms, string ends on the low surrogate
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);
        // code point above the unicode range as the last character: bare end marker
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // overlong form passes through
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // cut short at end of string, the rescan finds a two byte sequence
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        // cut short at end of string, every byte turns bad
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b1);
        directed_bytes = bytes_sent;

        // random strings of one to six characters
        while (bytes_sent < directed_bytes + RANDOM_BYTES)
        begin
            text_bytes.delete();
            n_chars = $urandom_range(1, 6);
            repeat (n_chars) append_char();
            foreach (text_bytes[k])
                send_byte(text_bytes[k], k == text_bytes.size() - 1);
        end
        s_tvalid <= 1'b0;

        // drain the outstanding units
        repeat (2) @(posedge clk);
        while (units_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d strings (%0d directed bytes)",
                 bytes_sent, strings_sent, directed_bytes);
        $display("checked %0d code units and end markers", units_checked);
        if (error_count == 0 && units_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d units outstanding", units_pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
